// ----- hdl/ppclsu_pkg.sv -----
// Shared types, codes and decode function for the integer load/store unit.
package ppclsu_pkg;

  typedef enum logic [4:0] {
    OP_STW   = 5'd0,
    OP_STWX  = 5'd1,
    OP_STWUX = 5'd2,
    OP_STH   = 5'd3,
    OP_STHX  = 5'd4,
    OP_STB   = 5'd5,
    OP_STBX  = 5'd6,
    OP_STBU  = 5'd7,
    OP_STWU  = 5'd8,
    OP_LWZ   = 5'd9,
    OP_LHZ   = 5'd10,
    OP_LBZX  = 5'd11,
    OP_LHA   = 5'd12,
    OP_LHZX  = 5'd13,
    OP_LBZ   = 5'd14,
    OP_LBZU  = 5'd15,
    OP_LWZU  = 5'd16,
    OP_LWZX  = 5'd17,
    OP_LWZUX = 5'd18,
    OP_LWBRX = 5'd19,
    OP_STMW  = 5'd20,
    OP_LMW   = 5'd21
  } op_t;

  // Address forms: (rA|0)+d, rA+d with GPR0 taken as-is, (rA|0)+rB
  typedef enum logic [1:0] {
    AM_BASE0_D,
    AM_RAW_D,
    AM_BASE0_X
  } amode_t;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd3;

  typedef struct packed {
    logic       legal;
    amode_t     amode;
    logic [1:0] size_m1;
    logic       store;
    logic       update;
    logic       sext;
    logic       brev;
    logic       multi;
  } dec_t;

  typedef enum logic [1:0] {
    RS_BASE,
    RS_INDEX,
    RS_CUR
  } rsel_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_RD_S,
    ST_ADDR,
    ST_MOD,
    ST_MEM,
    ST_MEM_END,
    ST_EMIT,
    ST_WB_A,
    ST_NEXT_RD,
    ST_NEXT_CAP
  } state_t;

  typedef struct packed {
    logic  accept;
    rsel_t rsel;
    logic  cap_a;
    logic  cap_b;
    logic  cap_s;
    logic  addr;
    logic  mem_step;
    logic  emit;
    logic  wb_a;
    logic  next_word;
    logic  clr;
  } cmd_t;

  typedef struct packed {
    dec_t dec;
    logic mod_done;
    logic byte_last;
    logic clr_last;
    logic out_free;
    logic reg_last;
  } stat_t;

  function automatic dec_t decode(input logic [4:0] mode);
    dec_t d;
    d = '{legal: 1'b1, amode: AM_BASE0_D, size_m1: SZ_WORD, store: 1'b0,
          update: 1'b0, sext: 1'b0, brev: 1'b0, multi: 1'b0};
    case (op_t'(mode))
      OP_STW: begin
        d.store = 1'b1;
      end
      OP_STWX: begin
        d.amode = AM_BASE0_X; d.store = 1'b1;
      end
      OP_STWUX: begin
        d.amode = AM_BASE0_X; d.store = 1'b1; d.update = 1'b1;
      end
      OP_STH: begin
        d.size_m1 = SZ_HALF; d.store = 1'b1;
      end
      OP_STHX: begin
        d.amode = AM_BASE0_X; d.size_m1 = SZ_HALF; d.store = 1'b1;
      end
      OP_STB: begin
        d.size_m1 = SZ_BYTE; d.store = 1'b1;
      end
      OP_STBX: begin
        d.amode = AM_BASE0_X; d.size_m1 = SZ_BYTE; d.store = 1'b1;
      end
      OP_STBU: begin
        d.amode = AM_RAW_D; d.size_m1 = SZ_BYTE; d.store = 1'b1; d.update = 1'b1;
      end
      OP_STWU: begin
        d.amode = AM_RAW_D; d.store = 1'b1; d.update = 1'b1;
      end
      OP_LWZ: begin
      end
      OP_LHZ: begin
        d.size_m1 = SZ_HALF;
      end
      OP_LBZX: begin
        d.amode = AM_BASE0_X; d.size_m1 = SZ_BYTE;
      end
      OP_LHA: begin
        d.size_m1 = SZ_HALF; d.sext = 1'b1;
      end
      OP_LHZX: begin
        d.amode = AM_BASE0_X; d.size_m1 = SZ_HALF;
      end
      OP_LBZ: begin
        d.size_m1 = SZ_BYTE;
      end
      OP_LBZU: begin
        d.amode = AM_RAW_D; d.size_m1 = SZ_BYTE; d.update = 1'b1;
      end
      OP_LWZU: begin
        d.amode = AM_RAW_D; d.update = 1'b1;
      end
      OP_LWZX: begin
        d.amode = AM_BASE0_X;
      end
      OP_LWZUX: begin
        d.amode = AM_BASE0_X; d.update = 1'b1;
      end
      OP_LWBRX: begin
        d.amode = AM_BASE0_X; d.brev = 1'b1;
      end
      OP_STMW: begin
        d.store = 1'b1; d.multi = 1'b1;
      end
      OP_LMW: begin
        d.multi = 1'b1;
      end
      default: begin
        d.legal = 1'b0;
      end
    endcase
    return d;
  endfunction

endpackage

// ----- hdl/ppclsu_req_if.sv -----
// Request and response channel interfaces of the load/store unit.
interface ppclsu_req_if;
  logic               valid;
  logic               ready;
  logic [4:0]         mode;
  logic [4:0]         reg_data;
  logic [4:0]         reg_base;
  logic [4:0]         reg_index;
  logic signed [15:0] displacement;

  modport source (output valid, mode, reg_data, reg_base, reg_index, displacement,
                  input ready);
  modport sink   (input valid, mode, reg_data, reg_base, reg_index, displacement,
                  output ready);
endinterface

interface ppclsu_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] eff_address;
  logic [31:0] data_value;
  logic [4:0]  dest_reg;
  logic        is_store;
  logic        base_updated;
  logic        last_access;

  modport source (output valid, eff_address, data_value, dest_reg, is_store,
                  base_updated, last_access, input ready);
  modport sink   (input valid, eff_address, data_value, dest_reg, is_store,
                  base_updated, last_access, output ready);
endinterface

// ----- hdl/ppclsu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ppclsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/ppclsu_ea_mod.sv -----
// Reduction of the 32-bit address modulo the memory size by reciprocal multiplication.
module ppclsu_ea_mod #(
  parameter int MEM_BYTES = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [31:0]                  dividend,
  output logic                         done,
  output logic [$clog2(MEM_BYTES)-1:0] rem
);

  localparam int AW = $clog2(MEM_BYTES);
  // floor(2^32 / N): the quotient estimate is at most one below the true quotient
  localparam logic [63:0] RECIP_W = 64'h1_0000_0000 / 64'(MEM_BYTES);
  localparam logic [31:0] RECIP   = RECIP_W[31:0];
  localparam logic [31:0] MODN    = 32'(MEM_BYTES);

  logic        mul_vld, sub_vld, fix_vld;
  logic [31:0] addr_q, quo_q, diff_q, quo_n, diff_fix;
  logic [63:0] prod;

  assign prod     = {32'd0, addr_q} * {32'd0, RECIP};
  assign quo_n    = quo_q * MODN;
  // difference is below 2N, one conditional subtract finishes it
  assign diff_fix = (diff_q >= MODN) ? diff_q - MODN : diff_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_vld <= 1'b0;
      sub_vld <= 1'b0;
      fix_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      mul_vld <= start;
      sub_vld <= mul_vld;
      fix_vld <= sub_vld;
      done    <= fix_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      addr_q <= dividend;
    end
    if (mul_vld) begin
      quo_q <= prod[63:32];
    end
    if (sub_vld) begin
      diff_q <= addr_q - quo_n;
    end
    if (fix_vld) begin
      rem <= diff_fix[AW-1:0];
    end
  end

endmodule

// ----- hdl/ppclsu_ctrl.sv -----
// Sequencing state machine of the load/store unit.
module ppclsu_ctrl import ppclsu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) state_next = ST_RD_A;
      end
      ST_RD_A: begin
        state_next = stat.dec.legal ? ST_RD_B : ST_IDLE;
      end
      ST_RD_B:     state_next = ST_RD_S;
      ST_RD_S:     state_next = ST_ADDR;
      ST_ADDR:     state_next = ST_MOD;
      ST_MOD: begin
        if (stat.mod_done) state_next = ST_MEM;
      end
      ST_MEM: begin
        if (stat.byte_last) state_next = ST_MEM_END;
      end
      ST_MEM_END:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (stat.out_free) begin
          if (stat.dec.update) begin
            state_next = ST_WB_A;
          end else if (stat.dec.multi && !stat.reg_last) begin
            state_next = ST_NEXT_RD;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_WB_A:     state_next = ST_IDLE;
      ST_NEXT_RD:  state_next = ST_NEXT_CAP;
      ST_NEXT_CAP: state_next = ST_MEM;
      default:     state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.rsel  = RS_CUR;
    req_ready = 1'b0;
    case (state)
      ST_CLEAR: cmd.clr = 1'b1;
      ST_IDLE: begin
        req_ready  = 1'b1;
        cmd.accept = req_valid;
      end
      ST_RD_A: cmd.rsel = RS_BASE;
      ST_RD_B: begin
        cmd.rsel  = RS_INDEX;
        cmd.cap_a = 1'b1;
      end
      ST_RD_S: begin
        cmd.rsel  = RS_CUR;
        cmd.cap_b = 1'b1;
      end
      ST_ADDR: begin
        cmd.cap_s = 1'b1;
        cmd.addr  = 1'b1;
      end
      ST_MEM: cmd.mem_step = 1'b1;
      ST_EMIT: begin
        cmd.emit      = stat.out_free;
        cmd.next_word = stat.out_free && !stat.dec.update && stat.dec.multi &&
                        !stat.reg_last;
      end
      ST_WB_A: cmd.wb_a = 1'b1;
      ST_NEXT_RD: cmd.rsel = RS_CUR;
      ST_NEXT_CAP: cmd.cap_s = 1'b1;
      default: begin
      end
    endcase
  end

endmodule

// ----- hdl/ppclsu_dp.sv -----
// Datapath: register file, byte memory, address arithmetic and result register.
module ppclsu_dp import ppclsu_pkg::*; #(
  parameter int MEM_BYTES = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic [4:0]         mode,
  input  logic [4:0]         reg_data,
  input  logic [4:0]         reg_base,
  input  logic [4:0]         reg_index,
  input  logic signed [15:0] displacement,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic [31:0]        eff_address,
  output logic [31:0]        data_value,
  output logic [4:0]         dest_reg,
  output logic               is_store,
  output logic               base_updated,
  output logic               last_access
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam logic [AW-1:0] ALAST = AW'(MEM_BYTES - 1);

  dec_t               dec;
  logic [4:0]         ra_q, rb_q, cur_reg;
  logic signed [15:0] disp_q;
  logic [31:0]        a_val, b_val, s_val, ea_q, acc;
  logic [AW-1:0]      byte_idx, clr_cnt;
  logic [1:0]         bcnt;
  logic               pend;
  logic [31:0]        rf_vld;

  // register file
  logic        rf_we;
  logic [4:0]  rf_waddr, rf_raddr, rf_raddr_q;
  logic [31:0] rf_wdata, rf_rdata, rf_val;

  // byte memory
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata, mem_rdata, s_byte;

  logic          mod_done;
  logic [AW-1:0] mod_rem;
  logic [31:0]   base, offs, ea_calc, load_val, store_val, res_val;
  logic [1:0]    bsel;

  always_comb begin
    case (cmd.rsel)
      RS_BASE:  rf_raddr = ra_q;
      RS_INDEX: rf_raddr = rb_q;
      default:  rf_raddr = cur_reg;
    endcase
  end

  // never-written registers read as zero
  assign rf_val = rf_vld[rf_raddr_q] ? rf_rdata : 32'd0;

  always_comb begin
    base = (dec.amode == AM_RAW_D || ra_q != 5'd0) ? a_val : 32'd0;
    offs = (dec.amode == AM_BASE0_X) ? b_val : {{16{disp_q[15]}}, disp_q};
    ea_calc = base + offs;
  end

  always_comb begin
    if (dec.sext) begin
      load_val = {{16{acc[15]}}, acc[15:0]};
    end else if (dec.brev) begin
      load_val = {acc[7:0], acc[15:8], acc[23:16], acc[31:24]};
    end else begin
      load_val = acc;
    end
    case (dec.size_m1)
      SZ_BYTE: store_val = {24'd0, s_val[7:0]};
      SZ_HALF: store_val = {16'd0, s_val[15:0]};
      default: store_val = s_val;
    endcase
    res_val = dec.store ? store_val : load_val;
  end

  // big-endian: first byte out is the most significant of the access
  assign bsel = dec.size_m1 - bcnt;
  always_comb begin
    case (bsel)
      2'd0:    s_byte = s_val[7:0];
      2'd1:    s_byte = s_val[15:8];
      2'd2:    s_byte = s_val[23:16];
      default: s_byte = s_val[31:24];
    endcase
  end

  assign rf_we    = (cmd.emit && !dec.store) || cmd.wb_a;
  assign rf_waddr = cmd.wb_a ? ra_q : cur_reg;
  assign rf_wdata = cmd.wb_a ? ea_q : load_val;

  assign mem_we    = cmd.clr || (cmd.mem_step && dec.store);
  assign mem_waddr = cmd.clr ? clr_cnt : byte_idx;
  assign mem_wdata = cmd.clr ? 8'd0 : s_byte;

  ppclsu_ram #(.WIDTH(32), .DEPTH(32)) u_rf (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_raddr),
    .rdata (rf_rdata)
  );

  ppclsu_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (byte_idx),
    .rdata (mem_rdata)
  );

  ppclsu_ea_mod #(.MEM_BYTES(MEM_BYTES)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.addr),
    .dividend (ea_calc),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld    <= '0;
      clr_cnt   <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
      bcnt      <= '0;
    end else begin
      if (rf_we) begin
        rf_vld[rf_waddr] <= 1'b1;
      end
      if (cmd.clr) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      pend <= cmd.mem_step && !dec.store;
      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cmd.addr) begin
        bcnt <= '0;
      end else if (cmd.mem_step) begin
        bcnt <= (bcnt == dec.size_m1) ? 2'd0 : bcnt + 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    rf_raddr_q <= rf_raddr;
    if (cmd.accept) begin
      dec     <= decode(mode);
      ra_q    <= reg_base;
      rb_q    <= reg_index;
      disp_q  <= displacement;
      cur_reg <= reg_data;
    end else if (cmd.next_word) begin
      cur_reg <= cur_reg + 1'b1;
    end
    if (cmd.cap_a) a_val <= rf_val;
    if (cmd.cap_b) b_val <= rf_val;
    if (cmd.cap_s) s_val <= rf_val;
    if (cmd.addr) begin
      ea_q <= ea_calc;
    end else if (cmd.next_word) begin
      ea_q <= ea_q + 32'd4;
    end
    if (cmd.addr || cmd.next_word) begin
      acc <= '0;
    end else if (pend) begin
      acc <= {acc[23:0], mem_rdata};
    end
    if (mod_done) begin
      byte_idx <= mod_rem;
    end else if (cmd.mem_step) begin
      byte_idx <= (byte_idx == ALAST) ? '0 : byte_idx + 1'b1;
    end
    if (cmd.emit) begin
      eff_address  <= ea_q;
      data_value   <= res_val;
      dest_reg     <= cur_reg;
      is_store     <= dec.store;
      base_updated <= dec.update;
      last_access  <= !dec.multi || (cur_reg == 5'd31);
    end
  end

  always_comb begin
    stat.dec       = dec;
    stat.mod_done  = mod_done;
    stat.byte_last = (bcnt == dec.size_m1);
    stat.clr_last  = (clr_cnt == ALAST);
    stat.out_free  = !rsp_valid || rsp_ready;
    stat.reg_last  = (cur_reg == 5'd31);
  end

endmodule

// ----- hdl/ppc_integer_load_store_unit.sv -----
// Top level of the integer load/store unit: controller plus datapath.
//
// Usage: one load or store instruction is a transfer on req (mode, reg_data,
// reg_base, reg_index, displacement). Each memory access it makes comes back as
// one transfer on rsp; lmw/stmw give one transfer per register S..31, the last
// marked by last_access. Unused modes give no transfer and change nothing.
// Timing: one instruction at a time. A single access is made of three reads
// through the single register file port, a 3-stage reduction of the address
// modulo MEM_BYTES (reciprocal multiply, multiply-subtract, one correction)
// followed by its registered done flag, and a memory that moves one byte a
// cycle; update forms add a write-back of rA. Each further word of lmw/stmw
// repeats a register read and the memory pass.
// Reset: the register file reads zero at once (per-register valid bits); the
// byte memory is cleared by a pass over all MEM_BYTES addresses, during which
// req.ready stays low.
// Stall: results sit in an output register; while rsp is stalled the unit
// finishes its work and waits in its emit step, then resumes when the register
// drains.
module ppc_integer_load_store_unit import ppclsu_pkg::*; #(
  parameter int MEM_BYTES = 4096
) (
  input logic         clk,
  input logic         rst,
  ppclsu_req_if.sink  req,
  ppclsu_rsp_if.source rsp
);

  cmd_t  cmd;
  stat_t stat;

  // sequencing
  ppclsu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // storage and arithmetic
  ppclsu_dp #(.MEM_BYTES(MEM_BYTES)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .mode         (req.mode),
    .reg_data     (req.reg_data),
    .reg_base     (req.reg_base),
    .reg_index    (req.reg_index),
    .displacement (req.displacement),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .eff_address  (rsp.eff_address),
    .data_value   (rsp.data_value),
    .dest_reg     (rsp.dest_reg),
    .is_store     (rsp.is_store),
    .base_updated (rsp.base_updated),
    .last_access  (rsp.last_access)
  );

endmodule

// ----- tb/tb_ppc_integer_load_store_unit.sv -----
// Self-checking testbench for the integer load/store unit: shadow model, random and directed traffic.
module tb_ppc_integer_load_store_unit;
  import ppclsu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MEM_BYTES     = 4096;
  localparam int NUM_GPR       = 32;
  localparam int LAST_GPR      = NUM_GPR - 1;
  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 11;
  // Worst case: every instruction an lmw/stmw of 32 words, each word waiting
  // out a stalled receiver, plus the memory clear pass, taken a few times over.
  localparam int LIMIT_CYCLES  = 1_200_000;
  // Longest quiet tail: a 32-word multiple plus margin.
  localparam int DRAIN_CYCLES  = 400;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 203;
  localparam int NUM_PHASES    = 4;
  localparam int MAX_REPORTS   = 10;

  // One memory access as reported on the response channel.
  typedef struct packed {
    logic [31:0] eff_address;
    logic [31:0] data_value;
    logic [4:0]  dest_reg;
    logic        is_store;
    logic        base_updated;
    logic        last_access;
  } access_t;

  // Shadow copy of the GPRs and byte memory; every accepted instruction is
  // executed here and the accesses it must produce are queued in order.
  class access_scoreboard;
    logic [31:0] shadow_gpr [NUM_GPR];
    logic [7:0]  shadow_mem [MEM_BYTES];
    access_t     expected_accesses [$];
    int unsigned errors;

    function new();
      foreach (shadow_gpr[i]) shadow_gpr[i] = '0;
      foreach (shadow_mem[i]) shadow_mem[i] = '0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return expected_accesses.size();
    endfunction

    // Byte k of an access wraps around the memory.
    function int unsigned byte_slot(logic [31:0] ea, int unsigned k);
      return ((ea % MEM_BYTES) + k) % MEM_BYTES;
    endfunction

    function logic [31:0] read_bytes(logic [31:0] ea, int unsigned nbytes);
      logic [31:0] v;
      v = '0;
      for (int unsigned k = 0; k < nbytes; k++)
        v = {v[23:0], shadow_mem[byte_slot(ea, k)]};
      return v;
    endfunction

    function void write_bytes(logic [31:0] ea, int unsigned nbytes, logic [31:0] v);
      for (int unsigned k = 0; k < nbytes; k++)
        shadow_mem[byte_slot(ea, k)] = 8'(v >> (8 * (nbytes - 1 - k)));
    endfunction

    function void queue_access(logic [31:0] ea, logic [31:0] v, logic [4:0] r,
                               logic st, logic upd, logic last);
      access_t a;
      a = '{eff_address: ea, data_value: v, dest_reg: r, is_store: st,
            base_updated: upd, last_access: last};
      expected_accesses.push_back(a);
    endfunction

    function void note_instruction(logic [4:0] mode, logic [4:0] rd, logic [4:0] ra,
                                   logic [4:0] rb, logic [15:0] disp);
      op_t         op;
      logic [31:0] offset;
      logic [31:0] base;
      logic [31:0] ea;
      logic [31:0] v;
      logic        upd;
      logic        st;
      int unsigned nbytes;
      if (mode > OP_LMW) return;
      op     = op_t'(mode);
      offset = {{16{disp[15]}}, disp};
      base   = (ra == 0) ? '0 : shadow_gpr[ra];
      case (op)
        OP_STBU, OP_STWU, OP_LBZU, OP_LWZU: ea = shadow_gpr[ra] + offset;
        OP_STWX, OP_STWUX, OP_STHX, OP_STBX, OP_LBZX, OP_LHZX,
        OP_LWZX, OP_LWZUX, OP_LWBRX: ea = base + shadow_gpr[rb];
        default: ea = base + offset;
      endcase
      case (op)
        OP_STH, OP_STHX, OP_LHZ, OP_LHZX, OP_LHA: nbytes = 2;
        OP_STB, OP_STBX, OP_STBU, OP_LBZ, OP_LBZX, OP_LBZU: nbytes = 1;
        default: nbytes = 4;
      endcase
      upd = op inside {OP_STWUX, OP_STWU, OP_STBU, OP_LBZU, OP_LWZU, OP_LWZUX};
      st  = op inside {OP_STW, OP_STWX, OP_STWUX, OP_STWU, OP_STH, OP_STHX,
                       OP_STB, OP_STBX, OP_STBU, OP_STMW};

      if (op == OP_STMW || op == OP_LMW) begin
        // Addresses are fixed at the start; lmw overwriting rA changes nothing.
        for (int r = rd; r < NUM_GPR; r++) begin
          if (st) begin
            v = shadow_gpr[r];
            write_bytes(ea, 4, v);
          end else begin
            v = read_bytes(ea, 4);
            shadow_gpr[r] = v;
          end
          queue_access(ea, v, 5'(r), st, 1'b0, r == LAST_GPR);
          ea += 32'd4;
        end
      end else if (st) begin
        // Value is taken before any base update (S equal to A).
        v = shadow_gpr[rd];
        if (nbytes == 2) v = {16'h0, v[15:0]};
        if (nbytes == 1) v = {24'h0, v[7:0]};
        write_bytes(ea, nbytes, v);
        if (upd) shadow_gpr[ra] = ea;
        queue_access(ea, v, rd, 1'b1, upd, 1'b1);
      end else begin
        v = read_bytes(ea, nbytes);
        if (op == OP_LHA) v = {{16{v[15]}}, v[15:0]};
        if (op == OP_LWBRX) v = {v[7:0], v[15:8], v[23:16], v[31:24]};
        // Base update lands after the load: rA wins when D equals A.
        shadow_gpr[rd] = v;
        if (upd) shadow_gpr[ra] = ea;
        queue_access(ea, v, rd, 1'b0, upd, 1'b1);
      end
    endfunction

    function void check_access(access_t got);
      access_t want;
      if (expected_accesses.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected access ea=%h data=%h reg=%0d st=%b upd=%b last=%b",
                   $time, got.eff_address, got.data_value, got.dest_reg, got.is_store,
                   got.base_updated, got.last_access);
        return;
      end
      want = expected_accesses.pop_front();
      if (got.eff_address !== want.eff_address || got.data_value !== want.data_value ||
          got.dest_reg !== want.dest_reg || got.is_store !== want.is_store ||
          got.base_updated !== want.base_updated ||
          got.last_access !== want.last_access) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: access mismatch", $time);
          $display("  expected ea=%h data=%h reg=%0d st=%b upd=%b last=%b",
                   want.eff_address, want.data_value, want.dest_reg, want.is_store,
                   want.base_updated, want.last_access);
          $display("  actual   ea=%h data=%h reg=%0d st=%b upd=%b last=%b",
                   got.eff_address, got.data_value, got.dest_reg, got.is_store,
                   got.base_updated, got.last_access);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  ppclsu_req_if req_ch();
  ppclsu_rsp_if rsp_ch();

  ppc_integer_load_store_unit #(
    .MEM_BYTES(MEM_BYTES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  access_scoreboard board = new();

  // Idle/stall odds in percent, set per phase by the stimulus process.
  int unsigned send_idle_pct  = 0;
  int unsigned rsp_stall_pct  = 0;
  // Hold-off request handed to the response process; it counts it down itself.
  int unsigned hold_request   = 0;
  int unsigned hold_left      = 0;

  // Idle pattern per phase: none, sender idle, receiver stalling, both lightly.
  int unsigned phase_idle_pct  [NUM_PHASES] = '{0, 65, 0, 12};
  int unsigned phase_stall_pct [NUM_PHASES] = '{0, 0, 65, 12};

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Response side: ready changes only at the falling edge. A pending hold-off
  // keeps ready low for a long stretch so the unit backs up into req.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
    end
  end

  // Every response transfer is checked at the rising edge it happens on.
  always @(posedge clk) begin : rsp_monitor
    access_t got;
    if (rsp_ch.valid && rsp_ch.ready) begin
      got = '{eff_address: rsp_ch.eff_address, data_value: rsp_ch.data_value,
              dest_reg: rsp_ch.dest_reg, is_store: rsp_ch.is_store,
              base_updated: rsp_ch.base_updated, last_access: rsp_ch.last_access};
      board.check_access(got);
    end
  end

  // Offer one instruction. Entered just after a rising edge (or at start);
  // random idle cycles go first, then valid stays up until the transfer.
  // Only one assignment to valid per falling edge, so back-to-back items
  // keep valid high without a glitch.
  task automatic send_instruction(input logic [4:0] mode, input logic [4:0] rd,
                                  input logic [4:0] ra, input logic [4:0] rb,
                                  input logic [15:0] disp);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.mode         <= mode;
    req_ch.reg_data     <= rd;
    req_ch.reg_base     <= ra;
    req_ch.reg_index    <= rb;
    req_ch.displacement <= disp;
    do @(posedge clk); while (!req_ch.ready);
    board.note_instruction(mode, rd, ra, rb, disp);
  endtask

  // Run limit, independent of the stimulus.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("[ppc_integer_load_store_unit] ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned phase;
    int unsigned pick;
    logic [4:0]  mode;
    logic [4:0]  rd;
    logic [4:0]  ra;
    logic [4:0]  rb;
    logic [15:0] disp;

    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.mode         = OP_STW;
    req_ch.reg_data     = '0;
    req_ch.reg_base     = '0;
    req_ch.reg_index    = '0;
    req_ch.displacement = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // req.ready stays low during the memory clear pass; the first transfer
    // simply waits for it.

    // ---- Directed part ----
    // Registers start at zero, so update forms seed them with addresses first.
    send_instruction(OP_LWZU,  5'd2,  5'd1,  5'd0,  16'h8000); // r1 = FFFF8000
    send_instruction(OP_STBU,  5'd31, 5'd0,  5'd0,  16'h7FFF); // raw GPR0 base
    send_instruction(OP_STWUX, 5'd0,  5'd0,  5'd1,  16'h0000); // A zero, S == A
    send_instruction(OP_STW,   5'd1,  5'd0,  5'd0,  16'h0100);
    send_instruction(OP_LHA,   5'd3,  5'd0,  5'd0,  16'h0102); // sign extends
    send_instruction(OP_LHZ,   5'd4,  5'd0,  5'd0,  16'h0102);
    send_instruction(OP_LBZ,   5'd5,  5'd0,  5'd0,  16'h0101);
    send_instruction(OP_LBZU,  5'd7,  5'd8,  5'd0,  16'h0100); // r8 = 0x100
    send_instruction(OP_LWBRX, 5'd6,  5'd0,  5'd8,  16'h0000);
    send_instruction(OP_LWZU,  5'd9,  5'd9,  5'd0,  16'h0100); // D == A
    send_instruction(OP_LWZUX, 5'd10, 5'd0,  5'd8,  16'h0000); // A zero, GPR0 updated
    send_instruction(OP_STH,   5'd1,  5'd8,  5'd0,  16'hFFFE);
    send_instruction(OP_STHX,  5'd3,  5'd8,  5'd8,  16'h0000);
    send_instruction(OP_STBX,  5'd5,  5'd0,  5'd8,  16'h0000);
    send_instruction(OP_LBZX,  5'd11, 5'd8,  5'd1,  16'h0000);
    send_instruction(OP_LHZX,  5'd12, 5'd8,  5'd1,  16'h0000);
    send_instruction(OP_LWZX,  5'd13, 5'd0,  5'd8,  16'h0000);
    send_instruction(OP_STWX,  5'd3,  5'd8,  5'd1,  16'h0000);
    send_instruction(OP_STW,   5'd1,  5'd0,  5'd0,  16'h0FFE); // wraps memory end
    send_instruction(OP_LWZ,   5'd14, 5'd0,  5'd0,  16'hFFFE); // same bytes, high EA
    send_instruction(OP_LWZ,   5'd15, 5'd31, 5'd0,  16'h7FFF);
    send_instruction(OP_STMW,  5'd0,  5'd0,  5'd0,  16'h0200); // all 32 registers
    send_instruction(OP_LMW,   5'd20, 5'd20, 5'd0,  16'h0250); // overwrites its base
    send_instruction(OP_LMW,   5'd31, 5'd0,  5'd0,  16'h0200);
    send_instruction(OP_STMW,  5'd31, 5'd31, 5'd31, 16'h8000);
    // Unused modes: no transfer on rsp, no state change.
    send_instruction(5'(OP_LMW + 1), 5'd31, 5'd31, 5'd31, 16'hFFFF);
    send_instruction(5'h1F,          5'd0,  5'd1,  5'd2,  16'h1234);

    // ---- Random part, split into idle phases ----
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase         = (sent * NUM_PHASES) / RANDOM_ITEMS;
      send_idle_pct = phase_idle_pct[phase];
      rsp_stall_pct = phase_stall_pct[phase];
      // Long hold-off once in the free-running phase: req backs up behind it.
      if (sent == 10) hold_request = HOLD_CYCLES;

      pick = $urandom_range(0, 99);
      if (pick < 8)
        mode = 5'($urandom_range(int'(OP_LMW) + 1, 31));
      else if (pick < 14)
        mode = ($urandom_range(0, 1) != 0) ? OP_STMW : OP_LMW;
      else
        mode = 5'($urandom_range(0, int'(OP_LWBRX)));

      // Keep most multiples short; a few move many registers.
      if ((mode == OP_STMW || mode == OP_LMW) && $urandom_range(0, 9) < 7)
        rd = 5'($urandom_range(24, LAST_GPR));
      else
        rd = 5'($urandom_range(0, LAST_GPR));
      ra = ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom_range(1, LAST_GPR));
      rb = 5'($urandom_range(0, LAST_GPR));

      // Mostly small offsets so loads land on bytes earlier stores wrote.
      pick = $urandom_range(0, 9);
      if (pick < 6)
        disp = 16'($urandom_range(0, 511)) - 16'd256;
      else
        disp = 16'($urandom());

      send_instruction(mode, rd, ra, rb, disp);
      sent++;
    end

    @(negedge clk);
    req_ch.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("[ppc_integer_load_store_unit] OK");
    end else begin
      $display("[ppc_integer_load_store_unit] ERROR");
    end
    $finish;
  end

endmodule
